// File: sv/pidc_pkg.sv
// pidc_pkg: shared types, constants and saturation helpers for the clamped PID block.
// Used by every module of pid_controller_clamped; depends on nothing else.
package pidc_pkg;

   // Sample, gain and accumulator formats
   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_WIDTH     = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int ACC_WIDTH      = 40;

   // Error and measured difference carry one extra bit
   localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
   // Signed product of a zero-extended gain and a difference, with room for negation
   localparam int PROD_WIDTH = GAIN_WIDTH + DIFF_WIDTH + 1;
   // Working width for saturating a product into the accumulator range
   localparam int WORK_WIDTH = ((PROD_WIDTH > ACC_WIDTH) ? PROD_WIDTH : ACC_WIDTH) + 1;

   // Configuration port
   localparam int CSR_DATA_WIDTH  = GAIN_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEG_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_MIN      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_MAX      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLAMP_ENABLE = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REVERSE      = 3'd6;

   // Signed sample range limits
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // Accumulator range limits
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [WORK_WIDTH-1:0] ACC_MAX_W =
      {{(WORK_WIDTH-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [WORK_WIDTH-1:0] ACC_MIN_W =
      {{(WORK_WIDTH-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

   // Beat payloads
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] measured;
      logic signed [SAMPLE_WIDTH-1:0] target;
   } pidc_req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] drive;
      logic                           saturated;
   } pidc_rsp_type;

   // Configuration register file contents
   typedef struct packed {
      logic [GAIN_WIDTH-1:0]          prop_gain;
      logic [GAIN_WIDTH-1:0]          integ_gain;
      logic [GAIN_WIDTH-1:0]          deriv_gain;
      logic signed [SAMPLE_WIDTH-1:0] out_min;
      logic signed [SAMPLE_WIDTH-1:0] out_max;
      logic                           clamp_enable;
      logic                           reverse;
   } pidc_cfg_type;

   // Pipeline load enables from the top-level flow control
   typedef struct packed {
      logic load_in;
      logic load_mul;
      logic load_out;
   } pidc_adv_type;

   // Saturated accumulator value with its hit flag
   typedef struct packed {
      logic                        sat;
      logic signed [ACC_WIDTH-1:0] val;
   } pidc_acc_sat_type;

   // Clip a product into the accumulator range
   function automatic pidc_acc_sat_type sat_prod(input logic signed [PROD_WIDTH-1:0] p);
      logic signed [WORK_WIDTH-1:0] w;
      pidc_acc_sat_type             r;
      w = {{(WORK_WIDTH-PROD_WIDTH){p[PROD_WIDTH-1]}}, p};
      if (w > ACC_MAX_W) begin
         r.sat = 1'b1;
         r.val = ACC_MAX;
      end else if (w < ACC_MIN_W) begin
         r.sat = 1'b1;
         r.val = ACC_MIN;
      end else begin
         r.sat = 1'b0;
         r.val = w[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   // Saturating add of two values already in the accumulator range
   function automatic pidc_acc_sat_type acc_add(input logic signed [ACC_WIDTH-1:0] a,
                                                input logic signed [ACC_WIDTH-1:0] b);
      logic [ACC_WIDTH:0] s;
      pidc_acc_sat_type   r;
      s = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
      r.sat = s[ACC_WIDTH] != s[ACC_WIDTH-1];
      if (r.sat) begin
         r.val = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         r.val = s[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// File: sv/pidc_mult_stage.sv
// pidc_mult_stage: input register, previous-sample state and the three gain products.
// Depends on pidc_pkg; load enables come from the top-level flow control.
module pidc_mult_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  pidc_pkg::pidc_adv_type            adv,
   input  pidc_pkg::pidc_cfg_type            cfg,
   input  pidc_pkg::pidc_req_type            req_data,
   output logic signed [pidc_pkg::ACC_WIDTH-1:0]    iprod,
   output logic signed [pidc_pkg::ACC_WIDTH-1:0]    pprod,
   output logic signed [pidc_pkg::ACC_WIDTH-1:0]    dprod,
   output logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] target,
   output logic                              prod_sat
);
   import pidc_pkg::*;

   pidc_req_type                    req_ff;
   logic signed [SAMPLE_WIDTH-1:0]  prev_meas_ff;
   logic signed [DIFF_WIDTH-1:0]    err;
   logic signed [DIFF_WIDTH-1:0]    dmeas;
   logic signed [PROD_WIDTH-1:0]    iprod_raw;
   logic signed [PROD_WIDTH-1:0]    pprod_raw;
   logic signed [PROD_WIDTH-1:0]    dprod_raw;
   pidc_acc_sat_type                isat;
   pidc_acc_sat_type                psat;
   pidc_acc_sat_type                dsat;
   logic signed [ACC_WIDTH-1:0]     iprod_ff;
   logic signed [ACC_WIDTH-1:0]     pprod_ff;
   logic signed [ACC_WIDTH-1:0]     dprod_ff;
   logic signed [SAMPLE_WIDTH-1:0]  target_ff;
   logic                            prod_sat_ff;

   // Hold the accepted beat
   always_ff @(posedge clock) begin
      if (adv.load_in) begin
         req_ff <= req_data;
      end
   end

   // Advance the previous sample as the beat moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_meas_ff <= '0;
      end else if (adv.load_mul) begin
         prev_meas_ff <= req_ff.measured;
      end
   end

   // Error and measured change, one bit wider than a sample
   always_comb begin
      err   = {req_ff.target[SAMPLE_WIDTH-1], req_ff.target}
            - {req_ff.measured[SAMPLE_WIDTH-1], req_ff.measured};
      dmeas = {req_ff.measured[SAMPLE_WIDTH-1], req_ff.measured}
            - {prev_meas_ff[SAMPLE_WIDTH-1], prev_meas_ff};
   end

   // Gain products, each clipped to the accumulator range
   always_comb begin
      iprod_raw = $signed({1'b0, cfg.integ_gain}) * err;
      pprod_raw = $signed({1'b0, cfg.prop_gain}) * err;
      dprod_raw = -($signed({1'b0, cfg.deriv_gain}) * dmeas);
      isat      = sat_prod(iprod_raw);
      psat      = sat_prod(pprod_raw);
      dsat      = sat_prod(dprod_raw);
   end

   // Register the products
   always_ff @(posedge clock) begin
      if (adv.load_mul) begin
         iprod_ff    <= isat.val;
         pprod_ff    <= psat.val;
         dprod_ff    <= dsat.val;
         target_ff   <= req_ff.target;
         prod_sat_ff <= isat.sat | psat.sat | dsat.sat;
      end
   end

   assign iprod    = iprod_ff;
   assign pprod    = pprod_ff;
   assign dprod    = dprod_ff;
   assign target   = target_ff;
   assign prod_sat = prod_sat_ff;

endmodule

// File: sv/pidc_out_stage.sv
// pidc_out_stage: integral state, total sum, scaling, clamp, reversal and result register.
// Depends on pidc_pkg; fed by pidc_mult_stage.
module pidc_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  pidc_pkg::pidc_adv_type            adv,
   input  pidc_pkg::pidc_cfg_type            cfg,
   input  logic signed [pidc_pkg::ACC_WIDTH-1:0]    iprod,
   input  logic signed [pidc_pkg::ACC_WIDTH-1:0]    pprod,
   input  logic signed [pidc_pkg::ACC_WIDTH-1:0]    dprod,
   input  logic signed [pidc_pkg::SAMPLE_WIDTH-1:0] target,
   input  logic                              prod_sat,
   output pidc_pkg::pidc_rsp_type            rsp_data
);
   import pidc_pkg::*;

   // Width after removing the gain fraction, and the wide working width
   localparam int SHIFT_WIDTH = ACC_WIDTH - GAIN_FRAC_BITS;
   localparam int Y_WIDTH     = ((SHIFT_WIDTH > 41) ? SHIFT_WIDTH : 41) + 2;
   localparam logic signed [Y_WIDTH-1:0] WIDE_POS =
      {{(Y_WIDTH-41){1'b0}}, 1'b1, {40{1'b0}}};
   localparam logic signed [Y_WIDTH-1:0] WIDE_NEG = -WIDE_POS;
   localparam logic signed [Y_WIDTH-1:0] SMAX_Y =
      {{(Y_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [Y_WIDTH-1:0] SMIN_Y =
      {{(Y_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [ACC_WIDTH-1:0]    integ_ff;
   pidc_acc_sat_type               iadd;
   pidc_acc_sat_type               padd;
   pidc_acc_sat_type               dadd;
   logic signed [ACC_WIDTH-1:0]    total_shift;
   logic signed [Y_WIDTH-1:0]      y_wide;
   logic signed [Y_WIDTH-1:0]      y_lim;
   logic signed [Y_WIDTH-1:0]      y_off;
   logic signed [Y_WIDTH-1:0]      y_clamp;
   logic signed [Y_WIDTH-1:0]      min_y;
   logic signed [Y_WIDTH-1:0]      max_y;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;
   logic                           out_sat;
   logic signed [SAMPLE_WIDTH-1:0] drive_in;
   logic                           rev_sat;
   pidc_rsp_type                   rsp_in;
   pidc_rsp_type                   rsp_ff;

   // Integral update and the two output adds
   always_comb begin
      iadd = acc_add(integ_ff, iprod);
      padd = acc_add(iadd.val, pprod);
      dadd = acc_add(padd.val, dprod);
   end

   // Floor shift, wide limit and setpoint offset
   always_comb begin
      total_shift = $signed(dadd.val) >>> GAIN_FRAC_BITS;
      y_wide      = {{(Y_WIDTH-SHIFT_WIDTH){total_shift[ACC_WIDTH-1]}},
                     total_shift[SHIFT_WIDTH-1:0]};
      if (y_wide > WIDE_POS) begin
         y_lim = WIDE_POS;
      end else if (y_wide < WIDE_NEG) begin
         y_lim = WIDE_NEG;
      end else begin
         y_lim = y_wide;
      end
      y_off = y_lim + {{(Y_WIDTH-SAMPLE_WIDTH){target[SAMPLE_WIDTH-1]}}, target};
   end

   // Optional clamp, upper bound tested first, then sample range
   always_comb begin
      min_y = {{(Y_WIDTH-SAMPLE_WIDTH){cfg.out_min[SAMPLE_WIDTH-1]}}, cfg.out_min};
      max_y = {{(Y_WIDTH-SAMPLE_WIDTH){cfg.out_max[SAMPLE_WIDTH-1]}}, cfg.out_max};
      y_clamp = y_off;
      if (cfg.clamp_enable) begin
         if (y_off > max_y) begin
            y_clamp = max_y;
         end else if (y_off < min_y) begin
            y_clamp = min_y;
         end
      end
      out_sat = 1'b0;
      if (y_clamp > SMAX_Y) begin
         y_sat   = SAMPLE_MAX;
         out_sat = 1'b1;
      end else if (y_clamp < SMIN_Y) begin
         y_sat   = SAMPLE_MIN;
         out_sat = 1'b1;
      end else begin
         y_sat = y_clamp[SAMPLE_WIDTH-1:0];
      end
   end

   // Optional negation, most negative value maps to most positive
   always_comb begin
      rev_sat  = 1'b0;
      drive_in = y_sat;
      if (cfg.reverse) begin
         if (y_sat == SAMPLE_MIN) begin
            drive_in = SAMPLE_MAX;
            rev_sat  = 1'b1;
         end else begin
            drive_in = -y_sat;
         end
      end
      rsp_in.drive     = drive_in;
      rsp_in.saturated = prod_sat | iadd.sat | padd.sat | dadd.sat | out_sat | rev_sat;
   end

   // Integral state advances with the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (adv.load_out) begin
         integ_ff <= iadd.val;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (adv.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/pid_controller_clamped.sv
// pid_controller_clamped: top level with the register file, flow control and both stages.
// Depends on pidc_pkg, pidc_mult_stage and pidc_out_stage.
//
// Usage:
//   Each req beat is one due sample (measured, target). Each accepted beat yields
//   exactly one rsp beat (drive, saturated), in order. A beat is taken at a rising
//   edge with valid high and stall low, on both channels.
//   The csr port writes one register per edge with csr_write high; csr_index picks
//   the register (gains 0..2, bounds 3..4, clamp enable 5, reverse 6); other indexes
//   are dropped. Write only while no beat is in flight.
//   Flow: an accepted req beat loads the input, product and result registers in that
//   order, and rsp_valid is high while the result register holds it. Throughput: one
//   beat per cycle while rsp_stall is low, set by the single integral
//   add-and-saturate path in the output stage.
//   Stall: the three registers form a pipeline that fills while rsp_stall is high;
//   req_stall rises only once all three hold beats and the receiver still stalls.
//   Reset: synchronous; empties the pipeline, clears the integral sum and previous
//   sample, and loads register defaults (gains 0, full-range bounds, clamp and
//   reverse off).
module pid_controller_clamped (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pidc_pkg::pidc_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pidc_pkg::pidc_rsp_type                 rsp_data,
   input  logic                                   csr_write,
   input  logic [pidc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pidc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import pidc_pkg::*;

   pidc_cfg_type                   cfg_ff;
   logic                           in_valid_ff;
   logic                           mul_valid_ff;
   logic                           out_valid_ff;
   logic                           adv_out;
   logic                           adv_mul;
   logic                           adv_in;
   pidc_adv_type                   adv;
   logic signed [ACC_WIDTH-1:0]    iprod;
   logic signed [ACC_WIDTH-1:0]    pprod;
   logic signed [ACC_WIDTH-1:0]    dprod;
   logic signed [SAMPLE_WIDTH-1:0] target;
   logic                           prod_sat;

   // Register file writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain    <= '0;
         cfg_ff.integ_gain   <= '0;
         cfg_ff.deriv_gain   <= '0;
         cfg_ff.out_min      <= SAMPLE_MIN;
         cfg_ff.out_max      <= SAMPLE_MAX;
         cfg_ff.clamp_enable <= 1'b0;
         cfg_ff.reverse      <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROP_GAIN: begin
               cfg_ff.prop_gain <= csr_wdata[GAIN_WIDTH-1:0];
            end
            CSR_INTEG_GAIN: begin
               cfg_ff.integ_gain <= csr_wdata[GAIN_WIDTH-1:0];
            end
            CSR_DERIV_GAIN: begin
               cfg_ff.deriv_gain <= csr_wdata[GAIN_WIDTH-1:0];
            end
            CSR_OUT_MIN: begin
               cfg_ff.out_min <= csr_wdata[SAMPLE_WIDTH-1:0];
            end
            CSR_OUT_MAX: begin
               cfg_ff.out_max <= csr_wdata[SAMPLE_WIDTH-1:0];
            end
            CSR_CLAMP_ENABLE: begin
               cfg_ff.clamp_enable <= csr_wdata[0];
            end
            CSR_REVERSE: begin
               cfg_ff.reverse <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stage advance: a stage loads when it is empty or its content moves on
   always_comb begin
      adv_out      = !out_valid_ff || !rsp_stall;
      adv_mul      = !mul_valid_ff || adv_out;
      adv_in       = !in_valid_ff || adv_mul;
      adv.load_in  = adv_in && req_valid;
      adv.load_mul = adv_mul && in_valid_ff;
      adv.load_out = adv_out && mul_valid_ff;
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_in) begin
            in_valid_ff <= req_valid;
         end
         if (adv_mul) begin
            mul_valid_ff <= in_valid_ff;
         end
         if (adv_out) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   assign req_stall = !adv_in;
   assign rsp_valid = out_valid_ff;

   pidc_mult_stage u_mult (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .iprod    (iprod),
      .pprod    (pprod),
      .dprod    (dprod),
      .target   (target),
      .prod_sat (prod_sat)
   );

   pidc_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg_ff),
      .iprod    (iprod),
      .pprod    (pprod),
      .dprod    (dprod),
      .target   (target),
      .prod_sat (prod_sat),
      .rsp_data (rsp_data)
   );

endmodule

// File: sv/pidc_checker.sv
// pidc_checker: port-level assertions for pid_controller_clamped, bound to the top level.
// Depends on pidc_pkg and pid_controller_clamped.
module pidc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input pidc_pkg::pidc_rsp_type rsp_data
);
   import pidc_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   // Come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // Stall the input only when the output is backed up
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled rsp beat");

   // Deliver an accepted beat on rsp_valid when the receiver does not stall in between
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && !req_stall, 3) && !$past(reset, 3) && !$past(reset, 1)
         && !$past(reset, 2) && !$past(rsp_stall, 1) && !$past(rsp_stall, 2)
         |-> rsp_valid)
      else $error("rsp beat late with no stall");

endmodule

bind pid_controller_clamped pidc_checker u_pidc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
